// ----- design/mwlc_pkg.sv -----
// Shared types, codes and reset constants for the motion warning lamp controller.
package mwlc_pkg;

    // Moving-average window depth
    localparam int unsigned WINDOW_DEFAULT = 8;

    // Sample and register widths
    localparam int unsigned SPEED_W     = 16;
    localparam int unsigned THRESHOLD_W = 15;
    localparam int unsigned FLASH_T_W   = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned LIMIT_W     = 32;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_STILL_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_ON_TIME   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_OFF_TIME  = 2'd2;

    // Configuration reset values
    localparam logic [THRESHOLD_W-1:0] STILL_THRESHOLD_RST = 15'd10;
    localparam logic [FLASH_T_W-1:0]   FLASH_ON_TIME_RST   = 16'd500;
    localparam logic [FLASH_T_W-1:0]   FLASH_OFF_TIME_RST  = 16'd500;

    // Lamp mode codes as seen on the result channel
    localparam logic [1:0] LAMP_MODE_OFF    = 2'd0;
    localparam logic [1:0] LAMP_MODE_STEADY = 2'd1;
    localparam logic [1:0] LAMP_MODE_FLASH  = 2'd2;

    // Lamp mode machine
    typedef enum logic [2:0] {
        MODE_OFF    = 3'b001,
        MODE_STEADY = 3'b010,
        MODE_FLASH  = 3'b100
    } mode_t;

    // Flash sequence: switch on, wait on-time, switch off, wait off-time
    typedef enum logic [3:0] {
        PH_ON       = 4'b0001,
        PH_ON_WAIT  = 4'b0010,
        PH_OFF      = 4'b0100,
        PH_OFF_WAIT = 4'b1000
    } phase_t;

endpackage

// ----- design/motion_warning_lamp_controller.sv -----
// Motion warning lamp controller: moving-average stillness test and lamp mode machine.
// An item passes through the input register and then the result register to the m_ channel.
// Throughput: one item per cycle unless m_ready holds the result; the input register feeds the
// single-pass update of the running sums and lamp machine, which writes the result register.
// The oldest sample comes from the history RAM, read when the item is taken in.
// Reset (aresetn low, synchronous) clears sums, slots, mode, flash phase and
// registers at once; history entries read as zero until written (per-entry valid bits).
module motion_warning_lamp_controller
    import mwlc_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration write port
    input  logic                    cfg_wen,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    // input channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [SPEED_W-1:0] s_linear_speed,
    input  logic signed [SPEED_W-1:0] s_angular_speed,
    input  logic                    s_human_in_view,
    input  logic [TIME_W-1:0]       s_now_ms,
    // result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_send_command,
    output logic                    m_lamp_on,
    output logic [1:0]              m_lamp_mode
);

    localparam int unsigned SLOT_W = $clog2(WINDOW);
    localparam int unsigned TOT_W  = SPEED_W + SLOT_W;
    localparam int unsigned HIST_W = 2 * SPEED_W;

    // configuration registers
    logic [THRESHOLD_W-1:0] still_threshold_reg;
    logic [FLASH_T_W-1:0]   flash_on_time_reg;
    logic [FLASH_T_W-1:0]   flash_off_time_reg;

    // input register
    logic                   in_valid_reg;
    logic [SPEED_W-1:0]     lin_reg;
    logic [SPEED_W-1:0]     ang_reg;
    logic                   human_reg;
    logic [TIME_W-1:0]      now_reg;
    logic                   old_valid_reg;

    // history bookkeeping
    logic [SLOT_W-1:0]      rd_slot_reg;
    logic [SLOT_W-1:0]      wr_slot_reg;
    logic [WINDOW-1:0]      entry_valid_reg;
    logic [HIST_W-1:0]      hist_rd_data;

    // running sums and lamp state
    logic [TOT_W-1:0]       lin_total_reg;
    logic [TOT_W-1:0]       ang_total_reg;
    logic [TOT_W-1:0]       lin_total_next;
    logic [TOT_W-1:0]       ang_total_next;
    mode_t                  mode_reg;
    mode_t                  mode_next;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [TIME_W-1:0]      phase_start_reg;
    logic [TIME_W-1:0]      phase_start_next;

    // result register
    logic                   out_valid_reg;
    logic                   send_reg;
    logic                   lamp_reg;
    logic [1:0]             lamp_mode_reg;
    logic                   send_next;
    logic                   lamp_next;
    logic [1:0]             lamp_mode_next;

    // datapath intermediates
    logic                   accept;
    logic                   advance;
    logic [SPEED_W-1:0]     old_lin;
    logic [SPEED_W-1:0]     old_ang;
    logic [TOT_W-1:0]       lin_mag;
    logic [TOT_W-1:0]       ang_mag;
    logic [LIMIT_W-1:0]     still_limit;
    logic                   moving;
    logic [TIME_W-1:0]      elapsed;

    // handshake: input register moves on when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            still_threshold_reg <= STILL_THRESHOLD_RST;
            flash_on_time_reg   <= FLASH_ON_TIME_RST;
            flash_off_time_reg  <= FLASH_OFF_TIME_RST;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_STILL_THRESHOLD: still_threshold_reg <= cfg_wdata[THRESHOLD_W-1:0];
                REG_FLASH_ON_TIME:   flash_on_time_reg   <= cfg_wdata[FLASH_T_W-1:0];
                REG_FLASH_OFF_TIME:  flash_off_time_reg  <= cfg_wdata[FLASH_T_W-1:0];
                default: ;
            endcase
        end
    end

    // sample history: written as an item leaves the input register, read on transfer
    mwlc_ram #(
        .WIDTH (HIST_W),
        .DEPTH (WINDOW)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (advance),
        .wr_addr (wr_slot_reg),
        .wr_data ({lin_reg, ang_reg}),
        .rd_en   (accept),
        .rd_addr (rd_slot_reg),
        .rd_data (hist_rd_data)
    );

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload and the validity of the slot being replaced
    always_ff @(posedge aclk) begin
        if (accept) begin
            lin_reg       <= s_linear_speed;
            ang_reg       <= s_angular_speed;
            human_reg     <= s_human_in_view;
            now_reg       <= s_now_ms;
            old_valid_reg <= entry_valid_reg[rd_slot_reg];
        end
    end

    // ring pointers and per-entry valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_slot_reg     <= '0;
            wr_slot_reg     <= '0;
            entry_valid_reg <= '0;
        end else begin
            if (accept) begin
                rd_slot_reg <= (rd_slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : rd_slot_reg + 1'b1;
            end
            if (advance) begin
                wr_slot_reg <= (wr_slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : wr_slot_reg + 1'b1;
                entry_valid_reg[wr_slot_reg] <= 1'b1;
            end
        end
    end

    // replaced sample, zero until its slot was first written
    assign old_lin = old_valid_reg ? hist_rd_data[HIST_W-1:SPEED_W] : '0;
    assign old_ang = old_valid_reg ? hist_rd_data[SPEED_W-1:0] : '0;

    // running sums: add the new sample, drop the oldest
    assign lin_total_next = lin_total_reg + {{(TOT_W-SPEED_W){lin_reg[SPEED_W-1]}}, lin_reg}
                          - {{(TOT_W-SPEED_W){old_lin[SPEED_W-1]}}, old_lin};
    assign ang_total_next = ang_total_reg + {{(TOT_W-SPEED_W){ang_reg[SPEED_W-1]}}, ang_reg}
                          - {{(TOT_W-SPEED_W){old_ang[SPEED_W-1]}}, old_ang};

    // stillness: |sum| <= threshold * WINDOW
    assign lin_mag = lin_total_next[TOT_W-1] ? (~lin_total_next + 1'b1) : lin_total_next;
    assign ang_mag = ang_total_next[TOT_W-1] ? (~ang_total_next + 1'b1) : ang_total_next;
    assign still_limit = LIMIT_W'(still_threshold_reg) * LIMIT_W'(WINDOW);
    assign moving = (LIMIT_W'(lin_mag) > still_limit) || (LIMIT_W'(ang_mag) > still_limit);

    assign elapsed = now_reg - phase_start_reg;

    // lamp mode transition, then the action of the new mode
    always_comb begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        send_next        = 1'b0;
        lamp_next        = 1'b0;

        case (mode_reg)
            MODE_OFF: begin
                if (moving && !human_reg) begin
                    mode_next = MODE_STEADY;
                end else if (moving && human_reg) begin
                    phase_next = PH_ON;
                    mode_next  = MODE_FLASH;
                end
            end
            MODE_FLASH: begin
                if (moving && !human_reg) begin
                    mode_next = MODE_STEADY;
                end else if (!moving) begin
                    mode_next = MODE_OFF;
                end
            end
            default: begin
                if (moving && human_reg) begin
                    phase_next = PH_ON;
                    mode_next  = MODE_FLASH;
                end else if (!moving) begin
                    mode_next = MODE_OFF;
                end
            end
        endcase

        case (mode_next)
            MODE_STEADY: begin
                send_next = 1'b1;
                lamp_next = 1'b1;
            end
            MODE_FLASH: begin
                case (phase_next)
                    PH_ON: begin
                        phase_start_next = now_reg;
                        send_next        = 1'b1;
                        lamp_next        = 1'b1;
                        phase_next       = PH_ON_WAIT;
                    end
                    PH_ON_WAIT: begin
                        if (elapsed >= TIME_W'(flash_on_time_reg)) begin
                            phase_next = PH_OFF;
                        end
                    end
                    PH_OFF: begin
                        phase_start_next = now_reg;
                        send_next        = 1'b1;
                        phase_next       = PH_OFF_WAIT;
                    end
                    default: begin
                        if (elapsed >= TIME_W'(flash_off_time_reg)) begin
                            phase_next = PH_ON;
                        end
                    end
                endcase
            end
            default: begin
                send_next = 1'b1;
            end
        endcase
    end

    // result mode code
    always_comb begin
        case (mode_next)
            MODE_STEADY: lamp_mode_next = LAMP_MODE_STEADY;
            MODE_FLASH:  lamp_mode_next = LAMP_MODE_FLASH;
            default:     lamp_mode_next = LAMP_MODE_OFF;
        endcase
    end

    // state update as an item passes into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_total_reg   <= '0;
            ang_total_reg   <= '0;
            mode_reg        <= MODE_OFF;
            phase_reg       <= PH_ON;
            phase_start_reg <= '0;
        end else if (advance) begin
            lin_total_reg   <= lin_total_next;
            ang_total_reg   <= ang_total_next;
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            phase_start_reg <= phase_start_next;
        end
    end

    // result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            send_reg      <= send_next;
            lamp_reg      <= lamp_next;
            lamp_mode_reg <= lamp_mode_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_send_command = send_reg;
    assign m_lamp_on      = lamp_reg;
    assign m_lamp_mode    = lamp_mode_reg;

    // read and write pointers agree whenever the input register is empty
    a_slots_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> (rd_slot_reg == wr_slot_reg))
        else $error("history read and write slots out of step");

    // a result without a relay command never turns the lamp on
    a_no_cmd_lamp_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_send_command) |-> !m_lamp_on)
        else $error("lamp_on set without a relay command");

    // steady mode always commands the lamp on
    a_steady_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_lamp_mode == LAMP_MODE_STEADY) |-> (m_send_command && m_lamp_on))
        else $error("steady mode without lamp-on command");

    // silent results only occur while flashing
    a_silent_flash: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_send_command) |-> (m_lamp_mode == LAMP_MODE_FLASH))
        else $error("missing relay command outside flashing mode");

endmodule

// ----- design/mwlc_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module mwlc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
